// ===== rtl/phcs_pkg.sv =====
// Shared constants, codes and types for the packet header checker.
// No dependencies; imported by packet_header_check_stats.
package phcs_pkg;

    localparam int NUM_TYPES     = 256;
    localparam int COUNTER_WIDTH = 64;
    localparam int IDX_W         = $clog2(NUM_TYPES);

    localparam int BYTE_W   = 8;
    localparam int POS_W    = 17;
    localparam int FIELD_W  = 16;
    localparam int RES_W    = 64;

    localparam logic [POS_W-1:0]   MIN_PACKET_LEN = POS_W'(13);
    localparam logic [FIELD_W-1:0] SYNC_VALUE     = 16'h90EB;
    localparam logic [POS_W-1:0]   POS_SYNC_LO    = POS_W'(0);
    localparam logic [POS_W-1:0]   POS_SYNC_HI    = POS_W'(1);
    localparam logic [POS_W-1:0]   POS_TYPE       = POS_W'(2);
    localparam logic [POS_W-1:0]   POS_LEN_LO     = POS_W'(9);
    localparam logic [POS_W-1:0]   POS_LEN_HI     = POS_W'(10);
    localparam logic [POS_W-1:0]   POS_LIMIT      = POS_W'(65536);

    // Stream payload widths: input tdata = data_byte, type_index;
    // output tdata = verdict, packet_type, count_value, bad_total (padded).
    localparam int S_TDATA_W = 16;
    localparam int M_PAY_W   = 2 + BYTE_W + RES_W + RES_W;
    localparam int M_TDATA_W = ((M_PAY_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        MODE_BYTE = 2'd0,
        MODE_TICK = 2'd1,
        MODE_READ = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_VERDICT = 2'd0,
        KIND_TICK    = 2'd1,
        KIND_COUNT   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        VERD_OK    = 2'd0,
        VERD_SHORT = 2'd1,
        VERD_SYNC  = 2'd2,
        VERD_LEN   = 2'd3
    } verdict_t;

    // Work carried from the accept stage into the counter stage.
    typedef struct packed {
        kind_t                    kind;
        verdict_t                 verdict;
        logic [BYTE_W-1:0]        ptype;
        logic [COUNTER_WIDTH-1:0] value;     // interval bytes for a tick
        logic [COUNTER_WIDTH-1:0] bad;       // rejected total for a tick
        logic                     inc;       // bump the type counter
        logic                     use_mem;   // report the type counter
        logic [IDX_W-1:0]         addr;
    } stage_t;

endpackage

// ===== rtl/phcs_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone, no package dependency.
module phcs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/packet_header_check_stats.sv =====
// Packet header checker with per-type packet counters.
// A transfer passes the counter stage register, then the output register; one
// transfer per cycle unless the output stalls. The type counter table is one RAM
// with one read-modify-write per packet, the following read forwarded from the
// write stage. Reset: asynchronous, active low; frame state, totals and the table
// valid bits clear at once, so the table reads as zero with no clearing pass.
module packet_header_check_stats (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] data_byte, [15:8] type_index
    input  logic [phcs_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]                       s_axis_tuser,
    // last_byte
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [1:0] verdict, [9:2] packet_type, [73:10] count_value,
    // [137:74] bad_total, [143:138] zero
    output logic [phcs_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // [1:0] result_kind
    output logic [1:0]                       m_axis_tuser
);

    import phcs_pkg::*;

    localparam int CW = COUNTER_WIDTH;

    // ---------------- input decode ----------------
    logic              accept;
    mode_t             mode;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] type_index;

    assign mode       = mode_t'(s_axis_tuser);
    assign data_byte  = s_axis_tdata[7:0];
    assign type_index = s_axis_tdata[15:8];
    assign accept     = s_axis_tvalid && s_axis_tready;

    // ---------------- frame and totals ----------------
    logic [POS_W-1:0]   pos_reg,      pos_next;
    logic [FIELD_W-1:0] sync_reg,     sync_next;
    logic [BYTE_W-1:0]  tbyte_reg,    tbyte_next;
    logic [FIELD_W-1:0] len_reg,      len_next;
    logic [CW-1:0]      interval_reg, interval_next;
    logic [CW-1:0]      rejected_reg, rejected_next;

    // ---------------- pipeline registers ----------------
    logic   s1_valid_reg, s1_valid_next;
    stage_t s1_reg,       s1_next;
    logic   out_valid_reg;
    kind_t  out_kind_reg;
    logic [M_PAY_W-1:0] out_pay_reg;

    logic s1_move;          // counter stage may hand its result on
    assign s1_move       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_move;

    // ---------------- accept stage ----------------
    logic [POS_W-1:0] count;
    verdict_t         verdict;
    logic             type_in_range;
    logic             idx_in_range;
    logic [IDX_W-1:0] rd_addr;

    // saturating byte count including this byte
    assign count   = pos_reg[POS_W-1] ? POS_LIMIT : pos_reg + POS_W'(1);

    assign type_in_range = {1'b0, tbyte_reg}  < (BYTE_W+1)'(NUM_TYPES);
    assign idx_in_range  = {1'b0, type_index} < (BYTE_W+1)'(NUM_TYPES);

    // Header fields land before byte 13, so a packet long enough to pass the
    // length test already has them in the registers.
    always_comb
    begin
        priority if (count < MIN_PACKET_LEN)
            verdict = VERD_SHORT;
        else if (sync_reg != SYNC_VALUE)
            verdict = VERD_SYNC;
        else if (count != {1'b0, len_reg})
            verdict = VERD_LEN;
        else
            verdict = VERD_OK;
    end

    assign rd_addr = (mode == MODE_READ) ? type_index[IDX_W-1:0] : tbyte_reg[IDX_W-1:0];

    always_comb
    begin
        pos_next      = pos_reg;
        sync_next     = sync_reg;
        tbyte_next    = tbyte_reg;
        len_next      = len_reg;
        interval_next = interval_reg;
        rejected_next = rejected_reg;
        s1_next       = s1_reg;
        s1_valid_next = s1_valid_reg;

        if (s_axis_tready)
        begin
            s1_valid_next = 1'b0;
        end

        if (accept)
        begin
            s1_next.kind    = KIND_VERDICT;
            s1_next.verdict = VERD_OK;
            s1_next.ptype   = '0;
            s1_next.value   = '0;
            s1_next.bad     = '0;
            s1_next.inc     = 1'b0;
            s1_next.use_mem = 1'b0;
            s1_next.addr    = rd_addr;

            unique case (mode)
                MODE_BYTE:
                begin
                    if (pos_reg == POS_SYNC_LO)
                        sync_next[7:0] = data_byte;
                    else if (pos_reg == POS_SYNC_HI)
                        sync_next[15:8] = data_byte;
                    else if (pos_reg == POS_TYPE)
                        tbyte_next = data_byte;
                    else if (pos_reg == POS_LEN_LO)
                        len_next[7:0] = data_byte;
                    else if (pos_reg == POS_LEN_HI)
                        len_next[15:8] = data_byte;
                    pos_next = count;

                    if (s_axis_tlast)
                    begin
                        s1_valid_next   = 1'b1;
                        s1_next.kind    = KIND_VERDICT;
                        s1_next.verdict = verdict;
                        if (verdict == VERD_OK)
                        begin
                            s1_next.ptype = tbyte_reg;
                            s1_next.inc   = type_in_range;
                            interval_next = interval_reg + CW'(count);
                        end
                        else
                        begin
                            rejected_next = rejected_reg + CW'(1);
                        end
                        pos_next   = '0;
                        sync_next  = '0;
                        tbyte_next = '0;
                        len_next   = '0;
                    end
                end
                MODE_TICK:
                begin
                    s1_valid_next = 1'b1;
                    s1_next.kind  = KIND_TICK;
                    s1_next.value = interval_reg;
                    s1_next.bad   = rejected_reg;
                    interval_next = '0;
                end
                MODE_READ:
                begin
                    s1_valid_next   = 1'b1;
                    s1_next.kind    = KIND_COUNT;
                    s1_next.ptype   = type_index;
                    s1_next.use_mem = idx_in_range;
                end
                MODE_NONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // ---------------- counter table ----------------
    logic              ram_we;
    logic [CW-1:0]     ram_wdata;
    logic [CW-1:0]     ram_rdata;
    logic              ram_re;
    logic [NUM_TYPES-1:0] vld_reg;
    logic              rd_vld_reg;
    logic              fwd_hit_reg;
    logic [CW-1:0]     fwd_data_reg;
    logic [CW-1:0]     operand;

    // Read on every transfer; the write of the counter stage happens on the
    // same edge, so a read of that entry takes the new value by forwarding.
    assign ram_re    = accept;
    assign ram_we    = s1_valid_reg && s1_move && s1_reg.inc;
    assign operand   = fwd_hit_reg ? fwd_data_reg : (rd_vld_reg ? ram_rdata : '0);
    assign ram_wdata = operand + CW'(1);

    phcs_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_TYPES)
    ) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_reg.addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            if (ram_we)
            begin
                vld_reg[s1_reg.addr] <= 1'b1;
            end
            if (ram_re)
            begin
                rd_vld_reg  <= vld_reg[rd_addr];
                fwd_hit_reg <= ram_we && (s1_reg.addr == rd_addr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            fwd_data_reg <= ram_wdata;
        end
    end

    // ---------------- state registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            sync_reg     <= '0;
            tbyte_reg    <= '0;
            len_reg      <= '0;
            interval_reg <= '0;
            rejected_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            sync_reg     <= sync_next;
            tbyte_reg    <= tbyte_next;
            len_reg      <= len_next;
            interval_reg <= interval_next;
            rejected_reg <= rejected_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    // ---------------- output register ----------------
    logic [CW-1:0] s1_count;
    assign s1_count = (s1_reg.kind == KIND_TICK) ? s1_reg.value
                    : (s1_reg.use_mem ? operand : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_valid_reg)
        begin
            out_kind_reg <= s1_reg.kind;
            out_pay_reg  <= {RES_W'(s1_reg.bad), RES_W'(s1_count),
                             s1_reg.ptype, s1_reg.verdict};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = M_TDATA_W'(out_pay_reg);

endmodule
